@@ sv/refcount_slot_table_defines.svh @@
// Assertion macros shared by the slot table RTL
`ifndef REFCOUNT_SLOT_TABLE_DEFINES_SVH
`define REFCOUNT_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define RST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot table assertion failed");

// Next-cycle implication, held off during reset
`define RST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot table assertion failed");

`endif

@@ sv/rcst_pkg.sv @@
// Constants, codes and types of the reference-counted slot table
package rcst_pkg;

    localparam int DEPTH      = 256;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int SPAN_W     = 9;
    localparam int END_W      = ADDR_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Request codes
    localparam logic [1:0] FN_SET     = 2'd0;
    localparam logic [1:0] FN_RETAIN  = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_REDIRECT  = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    // Per-slot bookkeeping word held in the metadata memory
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               alias_flag;
        logic [ADDR_W-1:0]  alias_base;
    } t_meta;

endpackage

@@ sv/refcount_slot_table.sv @@
// Reference-counted slot table: metadata and value memories with a read-modify-write sequencer
//
//  Channel  | Ports                                             | Handshake
//  ---------+---------------------------------------------------+---------------------------
//  request  | i_func i_slot_index i_new_value i_span_len        | start, taken when !busy
//  result   | o_status o_value_out o_value_valid o_target_index | o_done, one-cycle strobe
//           | o_cleanup_fired                                   |
//
// Retain, release and a rejected set do one memory read, then evaluate and write back any update.
// An accepted set writes its slot; the span walk then visits the rest of the clipped span one slot
// per cycle, marking free ones, reading the next slot while writing the current one.
// The result beat appears the cycle after evaluation; a set's span walk runs on after it.
// Synchronous active-low reset clears the per-slot valid bits, so every slot reads as free.
// The receiver cannot stall; busy alone holds requests off.
module refcount_slot_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_func,
    input  logic [rcst_pkg::ADDR_W-1:0]  i_slot_index,
    input  logic [rcst_pkg::DATA_W-1:0]  i_new_value,
    input  logic [rcst_pkg::SPAN_W-1:0]  i_span_len,
    output logic                         o_done,
    output logic [2:0]                   o_status,
    output logic [rcst_pkg::DATA_W-1:0]  o_value_out,
    output logic                         o_value_valid,
    output logic [rcst_pkg::ADDR_W-1:0]  o_target_index,
    output logic                         o_cleanup_fired
);

`include "refcount_slot_table_defines.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    localparam int ADDR_W  = rcst_pkg::ADDR_W;
    localparam int END_W   = rcst_pkg::END_W;
    localparam int DATA_W  = rcst_pkg::DATA_W;
    localparam int COUNT_W = rcst_pkg::COUNT_W;

    // Memories and per-slot valid bits
    rcst_pkg::t_meta     meta_mem [rcst_pkg::DEPTH];
    logic [DATA_W-1:0]   val_mem  [rcst_pkg::DEPTH];
    logic [rcst_pkg::DEPTH-1:0] r_vld;

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_func;
    logic [ADDR_W-1:0]   r_idx;
    logic [DATA_W-1:0]   r_val;
    logic [END_W-1:0]    r_end;
    logic [END_W-1:0]    r_ptr, n_ptr;

    rcst_pkg::t_meta     r_meta_q;
    logic                r_vld_q;
    logic [DATA_W-1:0]   r_val_q;
    rcst_pkg::t_meta     meta_eff;

    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    rcst_pkg::t_meta     wr_meta;
    logic                val_wr_en;

    logic                n_done;
    logic [2:0]          n_status;
    logic [DATA_W-1:0]   n_value_out;
    logic                n_value_valid;
    logic [ADDR_W-1:0]   n_target_index;
    logic                n_cleanup_fired;

    logic                accept;
    logic [END_W-1:0]    span_eff;
    logic [END_W:0]      end_raw;
    logic [END_W-1:0]    end_clip;
    logic                slot_busy;
    logic [END_W-1:0]    ptr_inc;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Clip the span at the table end; a zero span counts as one
    always_comb begin
        span_eff = (i_span_len == '0) ? END_W'(1) : END_W'(i_span_len);
        end_raw  = (END_W+1)'(i_slot_index) + (END_W+1)'(span_eff);
        end_clip = (end_raw > (END_W+1)'(rcst_pkg::DEPTH)) ? END_W'(rcst_pkg::DEPTH)
                                                          : end_raw[END_W-1:0];
    end

    // An entry never written reads as free
    assign meta_eff  = r_vld_q ? r_meta_q : '0;
    assign slot_busy = (meta_eff.count != '0) || meta_eff.alias_flag;
    assign ptr_inc   = r_ptr + END_W'(1);

    // Choose the read address for the next cycle
    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_addr = i_slot_index;
            S_EVAL:  rd_addr = r_idx + ADDR_W'(1);
            S_WALK:  rd_addr = ptr_inc[ADDR_W-1:0];
            default: rd_addr = i_slot_index;
        endcase
    end

    // Evaluate the addressed slot, decide the write-back and the result beat
    always_comb begin
        n_state         = r_state;
        n_ptr           = r_ptr;
        wr_en           = 1'b0;
        wr_addr         = r_idx;
        wr_meta         = meta_eff;
        val_wr_en       = 1'b0;
        n_done          = 1'b0;
        n_status        = rcst_pkg::ST_OK;
        n_value_out     = '0;
        n_value_valid   = 1'b0;
        n_target_index  = r_idx;
        n_cleanup_fired = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                unique case (r_func)
                    rcst_pkg::FN_SET: begin
                        if (slot_busy) begin
                            n_status        = rcst_pkg::ST_BUSY;
                            n_value_out     = r_val_q;
                            n_value_valid   = 1'b1;
                            n_cleanup_fired = 1'b1;
                        end else begin
                            wr_en              = 1'b1;
                            val_wr_en          = 1'b1;
                            wr_meta.count      = COUNT_W'(1);
                            wr_meta.alias_flag = 1'b0;
                            n_value_out        = r_val;
                            n_value_valid      = 1'b1;
                            n_ptr              = END_W'(r_idx) + END_W'(1);
                            if (END_W'(r_idx) + END_W'(1) < r_end) begin
                                n_state = S_WALK;
                            end
                        end
                    end
                    rcst_pkg::FN_RETAIN: begin
                        if (meta_eff.alias_flag) begin
                            n_status       = rcst_pkg::ST_REDIRECT;
                            n_target_index = meta_eff.alias_base;
                        end else if (meta_eff.count == '0) begin
                            n_status = rcst_pkg::ST_EMPTY;
                        end else if (meta_eff.count == rcst_pkg::COUNT_MAX) begin
                            n_status = rcst_pkg::ST_OVERFLOW;
                        end else begin
                            wr_en         = 1'b1;
                            wr_meta.count = meta_eff.count + COUNT_W'(1);
                            n_value_out   = r_val_q;
                            n_value_valid = 1'b1;
                        end
                    end
                    rcst_pkg::FN_RELEASE: begin
                        if (meta_eff.count == '0) begin
                            n_status = rcst_pkg::ST_UNDERFLOW;
                        end else begin
                            wr_en           = 1'b1;
                            wr_meta.count   = meta_eff.count - COUNT_W'(1);
                            n_cleanup_fired = (meta_eff.count == COUNT_W'(1));
                        end
                    end
                    default: begin
                        n_status = rcst_pkg::ST_OK;
                    end
                endcase
            end
            S_WALK: begin
                // Mark free slots of the span as aliases; busy ones keep their state
                wr_addr = r_ptr[ADDR_W-1:0];
                if (!slot_busy) begin
                    wr_en              = 1'b1;
                    wr_meta.count      = '0;
                    wr_meta.alias_flag = 1'b1;
                    wr_meta.alias_base = r_idx;
                end
                n_ptr = ptr_inc;
                if (ptr_inc >= r_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory ports: one registered read, one write per cycle
    always_ff @(posedge i_clk) begin
        r_meta_q <= meta_mem[rd_addr];
        r_val_q  <= val_mem[rd_addr];
        if (wr_en) begin
            meta_mem[wr_addr] <= wr_meta;
        end
        if (val_wr_en) begin
            val_mem[r_idx] <= r_val;
        end
    end

    // Valid bits: cleared by reset, set on first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            r_vld_q <= r_vld[rd_addr];
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Sequencer state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= n_done;
        end
    end

    // Capture the request beat and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_idx  <= i_slot_index;
            r_val  <= i_new_value;
            r_end  <= end_clip;
        end
        r_ptr           <= n_ptr;
        o_status        <= n_status;
        o_value_out     <= n_value_out;
        o_value_valid   <= n_value_valid;
        o_target_index  <= n_target_index;
        o_cleanup_fired <= n_cleanup_fired;
    end

    `RST_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `RST_ASSERT_NEXT(a_eval_done, r_state == S_EVAL, o_done)
    `RST_ASSERT_SAME(a_walk_bound, r_state == S_WALK, r_ptr < r_end)
    `RST_ASSERT_SAME(a_value_zero, o_done && !o_value_valid, o_value_out == '0)

endmodule
